### sv/spq_pkg.sv
// Shared types and constants for the stable max priority queue.
// No dependencies; imported by spq_cell and stable_max_priority_queue_top.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int QUEUE_DEPTH   = 64;
    localparam int SEVERITY_BITS = 16;
    localparam int TAG_BITS      = 16;

    // command codes carried on s_tuser
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_SERVE  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    // per-cycle operation broadcast to every cell
    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_INSERT = 2'd1;
    localparam logic [1:0] CELL_SERVE  = 2'd2;
    localparam logic [1:0] CELL_CLEAR  = 2'd3;

    typedef struct packed {
        logic                     valid;
        logic [SEVERITY_BITS-1:0] severity;
        logic [TAG_BITS-1:0]      tag;
    } entry_t;

    typedef struct packed {
        logic [1:0]               op;
        logic [SEVERITY_BITS-1:0] severity;
        logic [TAG_BITS-1:0]      tag;
    } cell_ctrl_t;

endpackage

`default_nettype wire

### sv/spq_cell.sv
// One slot of the sorted queue chain: holds one entry, shifts with neighbors.
// Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire spq_pkg::cell_ctrl_t ctrl,
    input  wire spq_pkg::entry_t    prev_entry,  // neighbor toward the head
    input  wire logic               prev_lt,     // neighbor ranks below new item
    input  wire spq_pkg::entry_t    next_entry,  // neighbor toward the tail
    output spq_pkg::entry_t         entry,
    output logic                    my_lt
);
    import spq_pkg::*;

    logic                     valid_reg, valid_next;
    logic [SEVERITY_BITS-1:0] sev_reg, sev_next;
    logic [TAG_BITS-1:0]      tag_reg, tag_next;

    // empty slot or strictly lower severity: new item goes ahead of us
    assign my_lt = !valid_reg || (sev_reg < ctrl.severity);

    always_comb begin
        valid_next = valid_reg;
        sev_next   = sev_reg;
        tag_next   = tag_reg;
        unique case (ctrl.op)
            CELL_INSERT: begin
                if (prev_lt) begin
                    valid_next = prev_entry.valid;
                    sev_next   = prev_entry.severity;
                    tag_next   = prev_entry.tag;
                end else if (my_lt) begin
                    valid_next = 1'b1;
                    sev_next   = ctrl.severity;
                    tag_next   = ctrl.tag;
                end
            end
            CELL_SERVE: begin
                valid_next = next_entry.valid;
                sev_next   = next_entry.severity;
                tag_next   = next_entry.tag;
            end
            CELL_CLEAR: begin
                valid_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        sev_reg <= sev_next;
        tag_reg <= tag_next;
    end

    assign entry.valid    = valid_reg;
    assign entry.severity = sev_reg;
    assign entry.tag      = tag_reg;

endmodule

`default_nettype wire

### sv/stable_max_priority_queue_top.sv
// Result timing: a result appears on m_* in the cycle after its item is accepted.
// Throughput: one item per cycle; the chain of cells updates at the edge that accepts
// the item, and only the single output register can stall the input side.
// Reset: synchronous active-low aresetn empties every slot and the output
// register; slot payloads are not reset. No clearing pass is needed.
// Depends on spq_pkg and spq_cell.
`timescale 1ns / 1ps
`default_nettype none

module stable_max_priority_queue_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] severity, [31:16] tag
    input  wire logic [1:0]  s_tuser,   // [1:0] cmd
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [15:0] served_tag, [31:16] served_severity
    output logic [0:0]       m_tuser    // [0] overflow
);
    import spq_pkg::*;

    // Slots are kept sorted: highest severity at cell 0, equal severities in
    // arrival order. An insert lands behind all entries of equal or higher
    // severity, so the head is always the earliest of the top severity.

    entry_t     cells [QUEUE_DEPTH];
    logic       lt    [QUEUE_DEPTH];
    cell_ctrl_t ctrl;

    logic                     accept;
    logic [1:0]               cmd;
    logic [SEVERITY_BITS-1:0] in_sev;
    logic [TAG_BITS-1:0]      in_tag;
    logic                     full;
    logic                     nonempty;

    // output register
    logic                     m_valid_reg, m_valid_next;
    logic [TAG_BITS-1:0]      m_tag_reg, m_tag_next;
    logic [SEVERITY_BITS-1:0] m_sev_reg, m_sev_next;
    logic                     m_ovf_reg, m_ovf_next;

    assign cmd    = s_tuser;
    assign in_sev = s_tdata[15:0];
    assign in_tag = s_tdata[31:16];

    // take a new item whenever the output register is free or draining
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign full     = cells[QUEUE_DEPTH-1].valid;
    assign nonempty = cells[0].valid;

    // broadcast to the chain; inserts into a full queue leave it untouched
    always_comb begin
        ctrl.op       = CELL_HOLD;
        ctrl.severity = in_sev;
        ctrl.tag      = in_tag;
        if (accept) begin
            unique case (cmd)
                CMD_INSERT: ctrl.op = full ? CELL_HOLD : CELL_INSERT;
                CMD_SERVE:  ctrl.op = nonempty ? CELL_SERVE : CELL_HOLD;
                CMD_CLEAR:  ctrl.op = CELL_CLEAR;
                CMD_NONE:   ctrl.op = CELL_HOLD;
                default:    ctrl.op = CELL_HOLD;
            endcase
        end
    end

    // the chain; head has no upstream neighbor, tail sees an empty slot
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        entry_t prev_e;
        entry_t next_e;
        logic   prev_l;

        if (i == 0) begin : g_head
            assign prev_e = '0;
            assign prev_l = 1'b0;
        end else begin : g_mid
            assign prev_e = cells[i-1];
            assign prev_l = lt[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign next_e = '0;
        end else begin : g_body
            assign next_e = cells[i+1];
        end

        spq_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .prev_entry (prev_e),
            .prev_lt    (prev_l),
            .next_entry (next_e),
            .entry      (cells[i]),
            .my_lt      (lt[i])
        );
    end

    // result: served head entry, or a dropped insert flagged as overflow
    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        m_tag_next   = m_tag_reg;
        m_sev_next   = m_sev_reg;
        m_ovf_next   = m_ovf_reg;
        if (accept) begin
            if (cmd == CMD_SERVE && nonempty) begin
                m_valid_next = 1'b1;
                m_tag_next   = cells[0].tag;
                m_sev_next   = cells[0].severity;
                m_ovf_next   = 1'b0;
            end else if (cmd == CMD_INSERT && full) begin
                m_valid_next = 1'b1;
                m_tag_next   = in_tag;
                m_sev_next   = in_sev;
                m_ovf_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_tag_reg <= m_tag_next;
        m_sev_reg <= m_sev_next;
        m_ovf_reg <= m_ovf_next;
    end

    assign m_tvalid       = m_valid_reg;
    assign m_tdata[15:0]  = m_tag_reg;
    assign m_tdata[31:16] = m_sev_reg;
    assign m_tuser[0]     = m_ovf_reg;

endmodule

`default_nettype wire

### tb/stable_max_priority_queue_top_test.sv
// Self-checking testbench for stable_max_priority_queue_top: directed table plus random phases,
// each result checked against an in-bench model of the triage queue or a pinned expectation.
// Depends on spq_pkg and the RTL of stable_max_priority_queue_top.
`timescale 1ns / 1ps

module stable_max_priority_queue_top_test;
    import spq_pkg::*;

    localparam int RAND_ITEMS     = 1875;
    localparam int CALM_TAIL      = 250;   // last items run with no idling
    localparam int WATCHDOG_LIMIT = 1000;  // cycles with no handshake at all
    localparam int DRAIN_LIMIT    = 600;
    localparam int SETTLE_CYCLES  = 10;
    localparam bit NO_RESULT      = 1'b0;
    localparam bit HAS_RESULT     = 1'b1;

    typedef logic [SEVERITY_BITS-1:0] sev_t;
    typedef logic [TAG_BITS-1:0]      tag_t;

    // one stimulus row; pinned rows carry a hand-written expectation
    typedef struct {
        logic [1:0] cmd;
        sev_t       sev;
        tag_t       tag;
        bit         pin;
        bit         pin_res;
        tag_t       exp_tag;
        sev_t       exp_sev;
        bit         exp_ovf;
    } plan_row_t;

    typedef struct {
        tag_t tag;
        sev_t sev;
        bit   ovf;
    } served_t;

    typedef struct {
        sev_t sev;
        tag_t tag;
    } waiting_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = CMD_NONE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;

    waiting_t  ward[$];        // entries in arrival order
    served_t   due[$];         // results still to come, oldest first
    plan_row_t plan[$];
    plan_row_t cur_item;       // row currently on s_*

    bit steady = 1'b0;         // no stalls on the result side
    bit gappy  = 1'b1;         // sender may idle between items
    int sent = 0;
    int directed_sent = 0;
    int checked = 0;
    int overflows = 0;
    int errors = 0;
    int quiet_cycles = 0;

    stable_max_priority_queue_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Model of the queue: highest severity out, earliest first among equals.
    function automatic void triage_step(input logic [1:0] cmd, input sev_t sev, input tag_t tag,
                                        output bit has, output served_t res);
        int best;
        int i;
        has = 1'b0;
        res = '{tag: '0, sev: '0, ovf: 1'b0};
        case (cmd)
            CMD_INSERT: begin
                if (ward.size() >= QUEUE_DEPTH) begin
                    has = 1'b1;
                    res = '{tag: tag, sev: sev, ovf: 1'b1};
                end else begin
                    ward.push_back('{sev: sev, tag: tag});
                end
            end
            CMD_SERVE: begin
                if (ward.size() > 0) begin
                    best = 0;
                    for (i = 1; i < ward.size(); i++)
                        if (ward[i].sev > ward[best].sev) best = i;
                    has = 1'b1;
                    res = '{tag: ward[best].tag, sev: ward[best].sev, ovf: 1'b0};
                    ward.delete(best);
                end
            end
            CMD_CLEAR: ward.delete();
            default: ;
        endcase
    endfunction

    function automatic plan_row_t free_row(logic [1:0] cmd, sev_t sev, tag_t tag);
        free_row = '{cmd: cmd, sev: sev, tag: tag, pin: 1'b0, pin_res: NO_RESULT,
                     exp_tag: '0, exp_sev: '0, exp_ovf: 1'b0};
    endfunction

    function automatic plan_row_t pin_row(logic [1:0] cmd, sev_t sev, tag_t tag, bit res,
                                          tag_t etag, sev_t esev, bit eovf);
        pin_row = '{cmd: cmd, sev: sev, tag: tag, pin: 1'b1, pin_res: res,
                    exp_tag: etag, exp_sev: esev, exp_ovf: eovf};
    endfunction

    // narrow severities force plenty of ties
    function automatic sev_t rand_sev(bit narrow);
        rand_sev = narrow ? sev_t'($urandom_range(0, 3)) : sev_t'($urandom_range(0, 65535));
    endfunction

    function automatic plan_row_t rand_row(bit narrow, bit noisy);
        int r;
        logic [1:0] cmd;
        r = $urandom_range(0, 99);
        if (noisy)        cmd = 2'($urandom_range(0, 3));
        else if (r < 52)  cmd = CMD_INSERT;
        else if (r < 92)  cmd = CMD_SERVE;
        else if (r < 96)  cmd = CMD_CLEAR;
        else              cmd = CMD_NONE;
        rand_row = free_row(cmd, rand_sev(narrow), tag_t'($urandom_range(0, 65535)));
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        errors++;
        $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
    endtask

    // Drive one item from a falling edge, hold it until accepted, return on the next falling edge.
    task automatic send_item(input plan_row_t it);
        if (gappy && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.cmd;
        s_tdata  <= {it.tag, it.sev};
        cur_item <= it;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        sent++;
    endtask

    // Result side: ready held high for stretches, dropped in short bursts; held high while steady.
    initial begin : result_sink
        int left;
        bit hold;
        left = 0;
        hold = 1'b1;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (steady) begin
                m_tready <= 1'b1;
                left = 0;
            end else begin
                if (left == 0) begin
                    hold = ($urandom_range(0, 2) != 0);
                    left = hold ? $urandom_range(1, 16) : $urandom_range(1, 4);
                end
                m_tready <= hold;
                left--;
            end
        end
    end

    // Checker first, then prediction for the item taken at this edge.
    always @(posedge aclk) begin : scoreboard
        served_t got;
        served_t want;
        served_t fresh;
        bit has;
        bit s_acc;
        bit m_acc;
        if (aresetn) begin
            s_acc = s_tvalid && s_tready;
            m_acc = m_tvalid && m_tready;
            if (m_acc) begin
                got = '{tag: m_tdata[15:0], sev: m_tdata[31:16], ovf: m_tuser[0]};
                checked++;
                if (got.ovf) overflows++;
                if (due.size() == 0) begin
                    flag_mismatch("unexpected result tag", got.tag, 0);
                end else begin
                    want = due.pop_front();
                    if (got.tag != want.tag) flag_mismatch("served_tag", got.tag, want.tag);
                    if (got.sev != want.sev) flag_mismatch("served_severity", got.sev, want.sev);
                    if (got.ovf != want.ovf) flag_mismatch("overflow", got.ovf, want.ovf);
                end
            end
            if (s_acc) begin
                triage_step(cur_item.cmd, cur_item.sev, cur_item.tag, has, fresh);
                if (cur_item.pin) begin
                    has = cur_item.pin_res;
                    fresh = '{tag: cur_item.exp_tag, sev: cur_item.exp_sev,
                              ovf: cur_item.exp_ovf};
                end
                if (has) due.push_back(fresh);
            end
            quiet_cycles = (s_acc || m_acc) ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin : stimulus
        plan_row_t it;
        int kind;
        int span;
        int waited;
        bit narrow;
        bit drained_once;
        drained_once = 1'b0;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // serve and unused code on an empty queue: nothing comes out
        plan.push_back(pin_row(CMD_SERVE, 16'h0000, 16'h0000, NO_RESULT, '0, '0, 1'b0));
        plan.push_back(pin_row(CMD_NONE,  16'hFFFF, 16'hFFFF, NO_RESULT, '0, '0, 1'b0));
        // extremes and ties at both ends of the severity range
        plan.push_back(pin_row(CMD_INSERT, 16'h0000, 16'h0000, NO_RESULT, '0, '0, 1'b0));
        plan.push_back(pin_row(CMD_INSERT, 16'hFFFF, 16'hFFFF, NO_RESULT, '0, '0, 1'b0));
        plan.push_back(pin_row(CMD_INSERT, 16'hFFFF, 16'h1234, NO_RESULT, '0, '0, 1'b0));
        plan.push_back(pin_row(CMD_INSERT, 16'h0000, 16'h5555, NO_RESULT, '0, '0, 1'b0));
        plan.push_back(pin_row(CMD_SERVE, 16'h0000, 16'h0000, HAS_RESULT,
                               16'hFFFF, 16'hFFFF, 1'b0));
        plan.push_back(pin_row(CMD_SERVE, 16'h0000, 16'h0000, HAS_RESULT,
                               16'h1234, 16'hFFFF, 1'b0));
        plan.push_back(pin_row(CMD_SERVE, 16'h0000, 16'h0000, HAS_RESULT,
                               16'h0000, 16'h0000, 1'b0));
        plan.push_back(pin_row(CMD_SERVE, 16'h0000, 16'h0000, HAS_RESULT,
                               16'h5555, 16'h0000, 1'b0));
        plan.push_back(pin_row(CMD_SERVE, 16'hFFFF, 16'hFFFF, NO_RESULT, '0, '0, 1'b0));
        // clear drops everything stored
        plan.push_back(pin_row(CMD_INSERT, 16'h8000, 16'hAAAA, NO_RESULT, '0, '0, 1'b0));
        plan.push_back(pin_row(CMD_INSERT, 16'h7FFF, 16'h5555, NO_RESULT, '0, '0, 1'b0));
        plan.push_back(pin_row(CMD_CLEAR, 16'hFFFF, 16'hFFFF, NO_RESULT, '0, '0, 1'b0));
        plan.push_back(pin_row(CMD_SERVE, 16'h0000, 16'h0000, NO_RESULT, '0, '0, 1'b0));
        // unused code leaves the stored entry alone
        plan.push_back(pin_row(CMD_INSERT, 16'h0001, 16'h0F0F, NO_RESULT, '0, '0, 1'b0));
        plan.push_back(pin_row(CMD_NONE,  16'hFFFF, 16'hFFFF, NO_RESULT, '0, '0, 1'b0));
        plan.push_back(pin_row(CMD_SERVE, 16'h0000, 16'h0000, HAS_RESULT,
                               16'h0F0F, 16'h0001, 1'b0));
        // middle values, checked by the model
        plan.push_back(free_row(CMD_INSERT, 16'h00A0, 16'h0001));
        plan.push_back(free_row(CMD_INSERT, 16'h0A00, 16'h0002));
        plan.push_back(free_row(CMD_INSERT, 16'h00A0, 16'h0003));
        plan.push_back(free_row(CMD_SERVE,  16'h0000, 16'h0000));
        plan.push_back(free_row(CMD_SERVE,  16'h0000, 16'h0000));
        plan.push_back(free_row(CMD_INSERT, 16'h3C3C, 16'hC3C3));
        plan.push_back(free_row(CMD_CLEAR,  16'h0000, 16'h0000));

        foreach (plan[i]) send_item(plan[i]);
        directed_sent = sent;

        while (sent < directed_sent + RAND_ITEMS) begin
            if (sent >= directed_sent + RAND_ITEMS - CALM_TAIL) begin
                steady = 1'b1;
                gappy  = 1'b0;
            end else begin
                steady = ($urandom_range(0, 3) == 0);
                gappy  = ($urandom_range(0, 3) != 0);
            end
            narrow = $urandom_range(0, 1);
            kind = $urandom_range(0, 4);
            case (kind)
                0, 1: begin
                    span = $urandom_range(40, 160);
                    repeat (span) send_item(rand_row(narrow, 1'b0));
                end
                2: begin
                    // fill to the top, push past it, then drain and serve once more
                    while (ward.size() < QUEUE_DEPTH) begin
                        it = rand_row(narrow, 1'b0);
                        it.cmd = ($urandom_range(0, 9) == 0) ? CMD_SERVE : CMD_INSERT;
                        send_item(it);
                    end
                    repeat ($urandom_range(1, 6))
                        send_item(free_row(CMD_INSERT, rand_sev(narrow),
                                           tag_t'($urandom_range(0, 65535))));
                    while (ward.size() > 0)
                        send_item(free_row(CMD_SERVE, rand_sev(1'b0),
                                           tag_t'($urandom_range(0, 65535))));
                    send_item(free_row(CMD_SERVE, rand_sev(1'b0),
                                       tag_t'($urandom_range(0, 65535))));
                end
                default: begin
                    span = $urandom_range(20, 60);
                    repeat (span) send_item(rand_row(narrow, 1'b1));
                end
            endcase
            // hold the sender until the result side has caught up; never in the calm tail
            if (!drained_once || (gappy && $urandom_range(0, 4) == 0)) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
                while (due.size() != 0) @(negedge aclk);
                drained_once = 1'b1;
            end
        end

        s_tvalid <= 1'b0;
        waited = 0;
        while (due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        if (due.size() != 0) flag_mismatch("results never delivered", 0, due.size());
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("run covered %0d items (%0d from the table), %0d results checked",
                 sent, directed_sent, checked);
        $display("  including %0d dropped inserts on a full queue; %0d mismatches",
                 overflows, errors);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
